/* rtl/evpf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the event plane-fit optical flow block.
// No dependencies.
package evpf_pkg;

  localparam int SENSOR_W       = 128;
  localparam int SENSOR_H       = 128;
  localparam int X_BITS         = 7;
  localparam int Y_BITS         = 7;
  localparam int STAMP_BITS     = 24;
  localparam int PIX_ADDR_BITS  = X_BITS + Y_BITS;
  localparam int PIXELS         = SENSOR_W * SENSOR_H;
  localparam int ENTRY_BITS     = STAMP_BITS + 1;
  localparam int CFG_BITS       = 5;
  localparam int MIN_EVENTS_RST = 5;
  localparam int NB_SIDE        = 5;
  localparam int NB_SIZE        = NB_SIDE * NB_SIDE;
  localparam int NB_IDX_BITS    = 5;
  localparam int FLOW_BITS      = 32;

  localparam logic [FLOW_BITS-2:0] Q_MAX = '1;

  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic signed [FLOW_BITS-1:0] flow_t;

endpackage

/* rtl/evpf_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module evpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/event_plane_fit_optical_flow.sv */
`timescale 1ns / 1ps
// Event optical flow by local plane fit over a per-pixel time surface.
// One event at a time: in_stall holds new events off until the result is
// emitted. Each event takes 25 surface reads, a scan of nine windows and,
// for a qualifying window with a positive determinant, two bit-serial divides.
// Reset: synchronous; a clearing pass over all 16384 entries empties the surface.
// Depends on evpf_pkg and evpf_ram.
module event_plane_fit_optical_flow (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [evpf_pkg::X_BITS-1:0]      in_ev_x,
  input  logic [evpf_pkg::Y_BITS-1:0]      in_ev_y,
  input  logic [evpf_pkg::STAMP_BITS-1:0]  in_ev_stamp,
  input  logic                             in_ev_channel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [evpf_pkg::X_BITS-1:0]      out_x,
  output logic [evpf_pkg::Y_BITS-1:0]      out_y,
  output logic [evpf_pkg::STAMP_BITS-1:0]  out_stamp,
  output logic                             out_has_flow,
  output logic signed [evpf_pkg::FLOW_BITS-1:0] out_flow_vx,
  output logic signed [evpf_pkg::FLOW_BITS-1:0] out_flow_vy,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [evpf_pkg::CFG_BITS-1:0]    cfg_min_events
);
  import evpf_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FETCH, S_SCAN, S_JUDGE, S_P1, S_P2, S_P3, S_P4,
    S_DSET, S_DIV, S_DFIN, S_SQ, S_LIM, S_INL, S_EMIT
  } state_t;

  state_t                   state_r;
  logic [PIX_ADDR_BITS-1:0] clr_cnt_r;
  logic [CFG_BITS-1:0]      min_ev_r;
  logic [X_BITS-1:0]        x_r;
  logic [Y_BITS-1:0]        y_r;
  stamp_t                   stamp_r;

  logic [2:0]             flx_r, fly_r;
  logic                   fdone_r, rd_v_r, rd_in_r;
  logic [NB_IDX_BITS-1:0] rd_k_r;
  logic                   nb_v_r   [NB_SIZE];
  stamp_t                 nb_age_r [NB_SIZE];

  logic [1:0] wdx_r, wdy_r, ppx_r, ppy_r;

  logic [3:0]         acc_n_r, b_n_r;
  logic signed [5:0]  acc_su_r, acc_sv_r, b_su_r, b_sv_r;
  logic signed [7:0]  acc_suu_r, acc_svv_r, acc_suv_r, b_suu_r, b_svv_r, b_suv_r;
  logic signed [29:0] acc_sw_r, b_sw_r;
  logic signed [30:0] acc_suw_r, acc_svw_r, b_suw_r, b_svw_r;
  logic [27:0]        acc_age_r, b_age_r;
  logic [1:0]         b_wdx_r, b_wdy_r;
  logic               found_r;

  logic signed [15:0] pk_svv_n_r, pk_sv_sv_r, pk_suv_n_r, pk_sv_su_r, pk_suv_sv_r, pk_svv_su_r;
  logic signed [39:0] pm_svw_n_r, pm_sv_sw_r, pm_svw_sv_r, pm_svv_sw_r, pm_suv_sw_r;
  logic signed [39:0] pm_svw_su_r;
  logic signed [15:0] k1_r, k2_r, k3_r;
  logic signed [39:0] m1_r, m2_r, m3_r;
  logic signed [23:0] td1_r, td2_r, td3_r, det_r;
  logic signed [47:0] ta1_r, ta2_r, ta3_r, tb1_r, tb2_r, tb3_r, na_r, nb_r;

  logic               sel_r, neg_r, sat_r;
  logic [23:0]        rem_r;
  logic [30:0]        dsh_r, q_r;
  logic [4:0]         dcnt_r;
  flow_t              fa_r, fb_r;
  logic [63:0]        aa_r, bb_r, lim_r;

  logic               s1_v_r, s2_v_r, idone_r, flow_r;
  logic signed [41:0] s1_r;
  logic [61:0]        s2_sq_r;
  logic [3:0]         cnt_r;

  logic               out_valid_r, out_has_flow_r;
  logic [X_BITS-1:0]  out_x_r;
  logic [Y_BITS-1:0]  out_y_r;
  stamp_t             out_stamp_r;
  flow_t              out_vx_r, out_vy_r;

  // surface port
  logic                     ram_we;
  logic [PIX_ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0]    ram_wdata, ram_rdata;
  logic                     in_acc;
  logic [8:0]               px9, py9;
  logic                     f_inr;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {y_r, x_r};
    ram_wdata = '0;
    if (state_r == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
    end else if (in_acc && !in_ev_channel) begin
      ram_we    = 1'b1;
      ram_waddr = {in_ev_y, in_ev_x};
      ram_wdata = {1'b1, in_ev_stamp};
    end
  end

  assign px9       = 9'(x_r) + 9'(flx_r) - 9'd2;
  assign py9       = 9'(y_r) + 9'(fly_r) - 9'd2;
  assign f_inr     = (px9 < 9'(SENSOR_W)) && (py9 < 9'(SENSOR_H));
  assign ram_raddr = {py9[Y_BITS-1:0], px9[X_BITS-1:0]};

  evpf_ram #(.WIDTH(ENTRY_BITS), .DEPTH(PIXELS)) u_surface (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // neighborhood pixel under the current window position
  logic [1:0]             cx, cy;
  logic [2:0]             lx, ly;
  logic [NB_IDX_BITS-1:0] nb_idx;
  logic signed [3:0]      cu, cv;
  logic                   cur_v;
  stamp_t                 cur_age;
  logic signed [25:0]     wneg;

  assign cx      = (state_r == S_INL) ? b_wdx_r : wdx_r;
  assign cy      = (state_r == S_INL) ? b_wdy_r : wdy_r;
  assign lx      = 3'(cx) + 3'(ppx_r);
  assign ly      = 3'(cy) + 3'(ppy_r);
  assign nb_idx  = NB_IDX_BITS'(ly) * NB_IDX_BITS'(NB_SIDE) + NB_IDX_BITS'(lx);
  assign cu      = $signed({1'b0, lx}) - 4'sd2;
  assign cv      = $signed({1'b0, ly}) - 4'sd2;
  assign cur_v   = nb_v_r[nb_idx];
  assign cur_age = nb_age_r[nb_idx];
  assign wneg    = -$signed({2'b00, cur_age});

  logic qual, better, pix_last, win_last;
  assign qual     = (acc_n_r != 4'd0) && ({1'b0, acc_n_r} >= min_ev_r);
  assign better   = !found_r ||
                    (32'(acc_age_r) * 32'(b_n_r) < 32'(b_age_r) * 32'(acc_n_r));
  assign pix_last = (ppx_r == 2'd2) && (ppy_r == 2'd2);
  assign win_last = (wdx_r == 2'd2) && (wdy_r == 2'd2);

  logic signed [4:0] n_s;
  assign n_s = $signed({1'b0, b_n_r});

  // divider
  logic signed [47:0] d_num;
  logic [47:0]        d_mag;
  logic [24:0]        d_r2;
  logic               d_ge;
  logic [23:0]        rem_nxt;
  logic [31:0]        d_val;
  flow_t              d_res;

  assign d_num   = sel_r ? nb_r : na_r;
  assign d_mag   = d_num[47] ? 48'(-d_num) : 48'(d_num);
  assign d_r2    = {rem_r, dsh_r[30]};
  assign d_ge    = d_r2 >= {1'b0, det_r};
  assign rem_nxt = d_ge ? 24'(d_r2 - {1'b0, det_r}) : d_r2[23:0];
  assign d_val   = sat_r ? {1'b0, Q_MAX} : {1'b0, q_r};
  assign d_res   = neg_r ? -$signed(d_val) : $signed(d_val);

  // inlier pipeline
  logic signed [41:0] r_nxt;
  logic [41:0]        s1_mag;
  assign r_nxt  = 42'(fa_r) * 42'(cu) + 42'(fb_r) * 42'(cv)
                + $signed({2'b00, cur_age, 16'h0000});
  assign s1_mag = s1_r[41] ? 42'(-s1_r) : 42'(s1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      min_ev_r    <= CFG_BITS'(MIN_EVENTS_RST);
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_ev_r <= cfg_min_events;
      end
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      rd_v_r <= (state_r == S_FETCH) && !fdone_r;
      if (rd_v_r) begin
        nb_v_r[rd_k_r]   <= ram_rdata[ENTRY_BITS-1] & rd_in_r;
        nb_age_r[rd_k_r] <= stamp_r - ram_rdata[STAMP_BITS-1:0];
      end

      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == PIX_ADDR_BITS'(PIXELS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && !in_ev_channel) begin
            x_r       <= in_ev_x;
            y_r       <= in_ev_y;
            stamp_r   <= in_ev_stamp;
            flx_r     <= '0;
            fly_r     <= '0;
            fdone_r   <= 1'b0;
            wdx_r     <= '0;
            wdy_r     <= '0;
            ppx_r     <= '0;
            ppy_r     <= '0;
            found_r   <= 1'b0;
            b_n_r     <= 4'd1;
            b_age_r   <= '0;
            acc_n_r   <= '0;
            acc_su_r  <= '0;
            acc_sv_r  <= '0;
            acc_suu_r <= '0;
            acc_svv_r <= '0;
            acc_suv_r <= '0;
            acc_sw_r  <= '0;
            acc_suw_r <= '0;
            acc_svw_r <= '0;
            acc_age_r <= '0;
            state_r   <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (!fdone_r) begin
            rd_in_r <= f_inr;
            rd_k_r  <= NB_IDX_BITS'(fly_r) * NB_IDX_BITS'(NB_SIDE) + NB_IDX_BITS'(flx_r);
            if (flx_r == 3'(NB_SIDE - 1)) begin
              flx_r <= '0;
              fly_r <= fly_r + 1'b1;
              if (fly_r == 3'(NB_SIDE - 1)) begin
                fdone_r <= 1'b1;
              end
            end else begin
              flx_r <= flx_r + 1'b1;
            end
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cur_v) begin
            acc_n_r   <= acc_n_r + 1'b1;
            acc_su_r  <= acc_su_r + 6'(cu);
            acc_sv_r  <= acc_sv_r + 6'(cv);
            acc_suu_r <= acc_suu_r + 8'(cu) * 8'(cu);
            acc_svv_r <= acc_svv_r + 8'(cv) * 8'(cv);
            acc_suv_r <= acc_suv_r + 8'(cu) * 8'(cv);
            acc_sw_r  <= acc_sw_r + 30'(wneg);
            acc_suw_r <= acc_suw_r + 31'(cu) * 31'(wneg);
            acc_svw_r <= acc_svw_r + 31'(cv) * 31'(wneg);
            acc_age_r <= acc_age_r + 28'(cur_age);
          end
          if (ppx_r == 2'd2) begin
            ppx_r <= '0;
            ppy_r <= (ppy_r == 2'd2) ? 2'd0 : ppy_r + 1'b1;
          end else begin
            ppx_r <= ppx_r + 1'b1;
          end
          if (pix_last) begin
            state_r <= S_JUDGE;
          end
        end
        S_JUDGE: begin
          if (qual && better) begin
            found_r  <= 1'b1;
            b_n_r    <= acc_n_r;
            b_su_r   <= acc_su_r;
            b_sv_r   <= acc_sv_r;
            b_suu_r  <= acc_suu_r;
            b_svv_r  <= acc_svv_r;
            b_suv_r  <= acc_suv_r;
            b_sw_r   <= acc_sw_r;
            b_suw_r  <= acc_suw_r;
            b_svw_r  <= acc_svw_r;
            b_age_r  <= acc_age_r;
            b_wdx_r  <= wdx_r;
            b_wdy_r  <= wdy_r;
          end
          acc_n_r   <= '0;
          acc_su_r  <= '0;
          acc_sv_r  <= '0;
          acc_suu_r <= '0;
          acc_svv_r <= '0;
          acc_suv_r <= '0;
          acc_sw_r  <= '0;
          acc_suw_r <= '0;
          acc_svw_r <= '0;
          acc_age_r <= '0;
          if (wdy_r == 2'd2) begin
            wdy_r <= '0;
            wdx_r <= wdx_r + 1'b1;
          end else begin
            wdy_r <= wdy_r + 1'b1;
          end
          if (win_last) begin
            flow_r  <= 1'b0;
            state_r <= (found_r || (qual && better)) ? S_P1 : S_EMIT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_P1: begin
          pk_svv_n_r  <= 16'(b_svv_r) * 16'(n_s);
          pk_sv_sv_r  <= 16'(b_sv_r) * 16'(b_sv_r);
          pk_suv_n_r  <= 16'(b_suv_r) * 16'(n_s);
          pk_sv_su_r  <= 16'(b_sv_r) * 16'(b_su_r);
          pk_suv_sv_r <= 16'(b_suv_r) * 16'(b_sv_r);
          pk_svv_su_r <= 16'(b_svv_r) * 16'(b_su_r);
          pm_svw_n_r  <= 40'(b_svw_r) * 40'(n_s);
          pm_sv_sw_r  <= 40'(b_sv_r) * 40'(b_sw_r);
          pm_svw_sv_r <= 40'(b_svw_r) * 40'(b_sv_r);
          pm_svv_sw_r <= 40'(b_svv_r) * 40'(b_sw_r);
          pm_suv_sw_r <= 40'(b_suv_r) * 40'(b_sw_r);
          pm_svw_su_r <= 40'(b_svw_r) * 40'(b_su_r);
          state_r     <= S_P2;
        end
        S_P2: begin
          k1_r    <= pk_svv_n_r - pk_sv_sv_r;
          k2_r    <= pk_suv_n_r - pk_sv_su_r;
          k3_r    <= pk_suv_sv_r - pk_svv_su_r;
          m1_r    <= pm_svw_n_r - pm_sv_sw_r;
          m2_r    <= pm_svw_sv_r - pm_svv_sw_r;
          m3_r    <= pm_suv_sw_r - pm_svw_su_r;
          state_r <= S_P3;
        end
        S_P3: begin
          td1_r   <= 24'(b_suu_r) * 24'(k1_r);
          td2_r   <= 24'(b_suv_r) * 24'(k2_r);
          td3_r   <= 24'(b_su_r) * 24'(k3_r);
          ta1_r   <= 48'(b_suw_r) * 48'(k1_r);
          ta2_r   <= 48'(b_suv_r) * 48'(m1_r);
          ta3_r   <= 48'(b_su_r) * 48'(m2_r);
          tb1_r   <= 48'(b_suu_r) * 48'(m1_r);
          tb2_r   <= 48'(b_suw_r) * 48'(k2_r);
          tb3_r   <= 48'(b_su_r) * 48'(m3_r);
          state_r <= S_P4;
        end
        S_P4: begin
          det_r   <= td1_r - td2_r + td3_r;
          na_r    <= ta1_r - ta2_r + ta3_r;
          nb_r    <= tb1_r - tb2_r + tb3_r;
          sel_r   <= 1'b0;
          state_r <= S_DSET;
        end
        S_DSET: begin
          if (det_r[23] || (det_r == 24'sd0)) begin
            state_r <= S_EMIT;
          end else begin
            neg_r   <= d_num[47];
            sat_r   <= d_mag >= 48'({det_r, 15'h0000});
            rem_r   <= d_mag[38:15];
            dsh_r   <= {d_mag[14:0], 16'h0000};
            q_r     <= '0;
            dcnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          dsh_r  <= {dsh_r[29:0], 1'b0};
          q_r    <= {q_r[29:0], d_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 5'd30) begin
            state_r <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (!sel_r) begin
            fa_r    <= d_res;
            sel_r   <= 1'b1;
            state_r <= S_DSET;
          end else begin
            fb_r    <= d_res;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          aa_r    <= 64'(fa_r) * 64'(fa_r);
          bb_r    <= 64'(fb_r) * 64'(fb_r);
          state_r <= S_LIM;
        end
        S_LIM: begin
          lim_r   <= aa_r + bb_r;
          ppx_r   <= '0;
          ppy_r   <= '0;
          idone_r <= 1'b0;
          s1_v_r  <= 1'b0;
          s2_v_r  <= 1'b0;
          cnt_r   <= '0;
          state_r <= S_INL;
        end
        S_INL: begin
          if (!idone_r) begin
            s1_v_r <= cur_v;
            s1_r   <= r_nxt;
            if (ppx_r == 2'd2) begin
              ppx_r <= '0;
              ppy_r <= ppy_r + 1'b1;
            end else begin
              ppx_r <= ppx_r + 1'b1;
            end
            if (pix_last) begin
              idone_r <= 1'b1;
            end
          end else begin
            s1_v_r <= 1'b0;
          end
          s2_v_r  <= s1_v_r && (s1_mag[41:31] == 11'd0);
          s2_sq_r <= 62'(s1_mag[30:0]) * 62'(s1_mag[30:0]);
          if (s2_v_r && ({s2_sq_r, 2'b00} < lim_r)) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (idone_r && !s1_v_r && !s2_v_r) begin
            flow_r  <= {1'b0, cnt_r} > min_ev_r;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r    <= 1'b1;
            out_x_r        <= x_r;
            out_y_r        <= y_r;
            out_stamp_r    <= stamp_r;
            out_has_flow_r <= flow_r;
            out_vx_r       <= flow_r ? fa_r : '0;
            out_vy_r       <= flow_r ? fb_r : '0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_stamp    = out_stamp_r;
  assign out_has_flow = out_has_flow_r;
  assign out_flow_vx  = out_vx_r;
  assign out_flow_vy  = out_vy_r;

`ifndef SYNTH
  a_store_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_ev_channel) |-> ram_we)
    else $error("accepted event not stored");

  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result beat raised outside emit");

  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_flow_r) |-> (out_vx_r == '0 && out_vy_r == '0))
    else $error("plain beat carries gradients");
`endif

endmodule
